/* rtl/qac_pkg.sv */
// ----------------------------------------------------------------------------
// qac_pkg: shared constants for the quadrilateral area and centroid block
// Holds the default coordinate width and the rule that sizes the area field.
// ----------------------------------------------------------------------------
package qac_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int AREA_WIDTH_MAX  = 64;

    // The area field is 2*W+2 bits wide, capped at 64 bits.
    function automatic int area_width(input int coord_width);
        return (2 * coord_width + 2 > AREA_WIDTH_MAX) ? AREA_WIDTH_MAX
                                                      : 2 * coord_width + 2;
    endfunction

endpackage

/* rtl/qac_div.sv */
// ----------------------------------------------------------------------------
// qac_div: pipelined centroid divider
// Restoring division of both first-moment magnitudes by a shared divisor,
// one quotient bit per stage, then saturation and the sign fix-up (corner average if degenerate).
// ----------------------------------------------------------------------------
module qac_div #(
    parameter int COORD_WIDTH = qac_pkg::COORD_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [3*COORD_WIDTH+3:0]                      i_num_x,
    input  logic [3*COORD_WIDTH+3:0]                      i_num_y,
    input  logic [2*COORD_WIDTH+4:0]                      i_den,
    input  logic                                          i_neg_x,
    input  logic                                          i_neg_y,
    input  logic                                          i_deg,
    input  logic [COORD_WIDTH-1:0]                        i_avg_x,
    input  logic [COORD_WIDTH-1:0]                        i_avg_y,
    input  logic [qac_pkg::area_width(COORD_WIDTH)-1:0]   i_area,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output logic [qac_pkg::area_width(COORD_WIDTH)-1:0]   o_area,
    output logic [COORD_WIDTH-1:0]                        o_cx,
    output logic [COORD_WIDTH-1:0]                        o_cy,
    output logic                                          o_deg
);
    import qac_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int NMW = 3 * W + 4;
    localparam int DW  = 2 * W + 5;
    localparam int AW  = area_width(W);
    localparam int NS  = W + 1;

    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MAG = {1'b1, {(W-1){1'b0}}};

    logic [NS-1:0]  r_v;
    logic [NS-1:0]  adv;
    logic           r_out_v;
    logic           out_adv;

    logic [NMW-1:0] r_rx   [NS];
    logic [NMW-1:0] r_ry   [NS];
    logic [W-1:0]   r_qx   [NS];
    logic [W-1:0]   r_qy   [NS];
    logic [DW-1:0]  r_d    [NS];
    logic           r_ovx  [NS];
    logic           r_ovy  [NS];
    logic           r_negx [NS];
    logic           r_negy [NS];
    logic           r_deg  [NS];
    logic [W-1:0]   r_avgx [NS];
    logic [W-1:0]   r_avgy [NS];
    logic [AW-1:0]  r_area [NS];

    logic [NMW-1:0] n_rx [1:W];
    logic [NMW-1:0] n_ry [1:W];
    logic [W-1:0]   n_qx [1:W];
    logic [W-1:0]   n_qy [1:W];

    logic [AW-1:0]  r_o_area;
    logic [W-1:0]   r_o_cx;
    logic [W-1:0]   r_o_cy;
    logic           r_o_deg;
    logic [W-1:0]   n_cx;
    logic [W-1:0]   n_cy;

    // A stage moves on when it is empty or the stage after it moves on.
    always_comb begin
        out_adv     = !r_out_v || i_ready;
        adv[NS-1]   = !r_v[NS-1] || out_adv;
        for (int j = NS - 2; j >= 0; j--) begin
            adv[j] = !r_v[j] || adv[j+1];
        end
    end

    assign o_ready = adv[0];

    // One quotient bit per stage; stage j decides bit W-j.
    always_comb begin
        logic [NMW-1:0] dsh;
        for (int j = 1; j <= W; j++) begin
            dsh     = {{(NMW-DW){1'b0}}, r_d[j-1]} << (W - j);
            n_rx[j] = r_rx[j-1];
            n_ry[j] = r_ry[j-1];
            n_qx[j] = r_qx[j-1];
            n_qy[j] = r_qy[j-1];
            if (r_rx[j-1] >= dsh) begin
                n_rx[j]        = r_rx[j-1] - dsh;
                n_qx[j][W - j] = 1'b1;
            end
            if (r_ry[j-1] >= dsh) begin
                n_ry[j]        = r_ry[j-1] - dsh;
                n_qy[j][W - j] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j < NS; j++) begin
                if (adv[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
            if (out_adv) begin
                r_out_v <= r_v[NS-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_rx[0]   <= i_num_x;
            r_ry[0]   <= i_num_y;
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            r_d[0]    <= i_den;
            // The quotient overflows the W result bits when n >= d * 2^W.
            r_ovx[0]  <= {1'b0, i_num_x} >= {i_den, {W{1'b0}}};
            r_ovy[0]  <= {1'b0, i_num_y} >= {i_den, {W{1'b0}}};
            r_negx[0] <= i_neg_x;
            r_negy[0] <= i_neg_y;
            r_deg[0]  <= i_deg;
            r_avgx[0] <= i_avg_x;
            r_avgy[0] <= i_avg_y;
            r_area[0] <= i_area;
        end
        for (int j = 1; j < NS; j++) begin
            if (adv[j]) begin
                r_rx[j]   <= n_rx[j];
                r_ry[j]   <= n_ry[j];
                r_qx[j]   <= n_qx[j];
                r_qy[j]   <= n_qy[j];
                r_d[j]    <= r_d[j-1];
                r_ovx[j]  <= r_ovx[j-1];
                r_ovy[j]  <= r_ovy[j-1];
                r_negx[j] <= r_negx[j-1];
                r_negy[j] <= r_negy[j-1];
                r_deg[j]  <= r_deg[j-1];
                r_avgx[j] <= r_avgx[j-1];
                r_avgy[j] <= r_avgy[j-1];
                r_area[j] <= r_area[j-1];
            end
        end
    end

    // Saturate the magnitude, restore the sign, or take the corner average.
    always_comb begin
        logic [W-1:0] mag_x;
        logic [W-1:0] mag_y;
        if (r_negx[NS-1]) begin
            mag_x = (r_ovx[NS-1] || r_qx[NS-1] > NEG_MAG) ? NEG_MAG : r_qx[NS-1];
            n_cx  = -mag_x;
        end else begin
            mag_x = (r_ovx[NS-1] || r_qx[NS-1] > POS_MAX) ? POS_MAX : r_qx[NS-1];
            n_cx  = mag_x;
        end
        if (r_negy[NS-1]) begin
            mag_y = (r_ovy[NS-1] || r_qy[NS-1] > NEG_MAG) ? NEG_MAG : r_qy[NS-1];
            n_cy  = -mag_y;
        end else begin
            mag_y = (r_ovy[NS-1] || r_qy[NS-1] > POS_MAX) ? POS_MAX : r_qy[NS-1];
            n_cy  = mag_y;
        end
        if (r_deg[NS-1]) begin
            n_cx = r_avgx[NS-1];
            n_cy = r_avgy[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_o_area <= r_area[NS-1];
            r_o_cx   <= n_cx;
            r_o_cy   <= n_cy;
            r_o_deg  <= r_deg[NS-1];
        end
    end

    assign o_valid = r_out_v;
    assign o_area  = r_o_area;
    assign o_cx    = r_o_cx;
    assign o_cy    = r_o_cy;
    assign o_deg   = r_o_deg;

endmodule

/* rtl/quad_area_centroid.sv */
// Throughput: one cell per cycle unless the output stalls; the divider has one register stage per quotient bit.
// Back-pressure freezes only the stages that are full, so bubbles are squeezed out.
// Reset (synchronous, active low) clears every valid bit; the data path is not reset.
// ----------------------------------------------------------------------------
// quad_area_centroid: shoelace area and centroid of a quadrilateral cell
// Six arithmetic stages form the cross products, twice the area and the
// first moments; a pipelined divider then produces the saturated centroid.
// ----------------------------------------------------------------------------
module quad_area_centroid #(
    parameter int COORD_WIDTH = qac_pkg::COORD_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_in_valid,
    output logic                                          o_in_ready,
    input  logic [COORD_WIDTH-1:0]                        i_corner0_x,
    input  logic [COORD_WIDTH-1:0]                        i_corner0_y,
    input  logic [COORD_WIDTH-1:0]                        i_corner1_x,
    input  logic [COORD_WIDTH-1:0]                        i_corner1_y,
    input  logic [COORD_WIDTH-1:0]                        i_corner2_x,
    input  logic [COORD_WIDTH-1:0]                        i_corner2_y,
    input  logic [COORD_WIDTH-1:0]                        i_corner3_x,
    input  logic [COORD_WIDTH-1:0]                        i_corner3_y,
    output logic                                          o_out_valid,
    input  logic                                          i_out_ready,
    output logic [qac_pkg::area_width(COORD_WIDTH)-1:0]   o_signed_area,
    output logic [COORD_WIDTH-1:0]                        o_centroid_x,
    output logic [COORD_WIDTH-1:0]                        o_centroid_y,
    output logic                                          o_degenerate
);
    import qac_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int TW  = 2 * W + 3;   // twice the area
    localparam int HAW = 2 * W + 2;   // magnitude of the area before saturation
    localparam int MW  = 3 * W + 2;   // one first-moment term
    localparam int NMW = 3 * W + 4;   // first-moment sum
    localparam int DW  = 2 * W + 5;   // three times twice the area
    localparam int AW  = area_width(W);
    localparam int NF  = 6;           // front-end stages ahead of the divider

    // Largest positive area that the output field holds.
    localparam logic [HAW-1:0] ALIM = {{(HAW-AW+1){1'b0}}, {(AW-1){1'b1}}};

    logic signed [W-1:0] cx [4];
    logic signed [W-1:0] cy [4];

    assign cx[0] = i_corner0_x;
    assign cy[0] = i_corner0_y;
    assign cx[1] = i_corner1_x;
    assign cy[1] = i_corner1_y;
    assign cx[2] = i_corner2_x;
    assign cy[2] = i_corner2_y;
    assign cx[3] = i_corner3_x;
    assign cy[3] = i_corner3_y;

    // ------------------------------------------------------------------------
    // Stage handshake. Each stage advances when it is empty or when the stage
    // after it advances; the last front stage waits on the divider.
    // ------------------------------------------------------------------------
    logic [NF-1:0] r_v;
    logic [NF-1:0] adv;
    logic          div_ready;

    always_comb begin
        adv[NF-1] = !r_v[NF-1] || div_ready;
        for (int k = NF - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_in_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NF; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: the eight coordinate products, the edge sums and corner sums.
    // Corners are taken cyclically, so the fourth pairs with the first.
    // ------------------------------------------------------------------------
    logic signed [2*W-1:0] r1_pa [4];
    logic signed [2*W-1:0] r1_pb [4];
    logic signed [W:0]     r1_sx [4];
    logic signed [W:0]     r1_sy [4];
    logic signed [W+1:0]   r1_sumx;
    logic signed [W+1:0]   r1_sumy;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            for (int k = 0; k < 4; k++) begin
                r1_pa[k] <= cx[k] * cy[(k+1)%4];
                r1_pb[k] <= cx[(k+1)%4] * cy[k];
                r1_sx[k] <= {cx[k][W-1], cx[k]} + {cx[(k+1)%4][W-1], cx[(k+1)%4]};
                r1_sy[k] <= {cy[k][W-1], cy[k]} + {cy[(k+1)%4][W-1], cy[(k+1)%4]};
            end
            r1_sumx <= cx[0] + cx[1] + cx[2] + cx[3];
            r1_sumy <= cy[0] + cy[1] + cy[2] + cy[3];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: the shoelace cross products, and the corner average with a
    // floor shift, kept in case the cell turns out to be degenerate.
    // ------------------------------------------------------------------------
    logic signed [2*W:0] r2_w [4];
    logic signed [W:0]   r2_sx [4];
    logic signed [W:0]   r2_sy [4];
    logic [W-1:0]        r2_avgx;
    logic [W-1:0]        r2_avgy;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            for (int k = 0; k < 4; k++) begin
                r2_w[k]  <= r1_pa[k] - r1_pb[k];
                r2_sx[k] <= r1_sx[k];
                r2_sy[k] <= r1_sy[k];
            end
            r2_avgx <= r1_sumx[W+1:2];
            r2_avgy <= r1_sumy[W+1:2];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: twice the area, and the moment products split into a low half
    // (the W low bits of the cross product, unsigned) and a signed high half
    // so that no multiplier is wider than (W+1) by (W+1) bits.
    // ------------------------------------------------------------------------
    logic signed [TW-1:0]  r3_twice;
    logic signed [2*W+1:0] r3_plx [4];
    logic signed [2*W+1:0] r3_phx [4];
    logic signed [2*W+1:0] r3_ply [4];
    logic signed [2*W+1:0] r3_phy [4];
    logic [W-1:0]          r3_avgx;
    logic [W-1:0]          r3_avgy;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r3_twice <= r2_w[0] + r2_w[1] + r2_w[2] + r2_w[3];
            for (int k = 0; k < 4; k++) begin
                r3_plx[k] <= r2_sx[k] * $signed({1'b0, r2_w[k][W-1:0]});
                r3_phx[k] <= r2_sx[k] * $signed(r2_w[k][2*W:W]);
                r3_ply[k] <= r2_sy[k] * $signed({1'b0, r2_w[k][W-1:0]});
                r3_phy[k] <= r2_sy[k] * $signed(r2_w[k][2*W:W]);
            end
            r3_avgx <= r2_avgx;
            r3_avgy <= r2_avgy;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: rejoin the partial products, form three times twice the area,
    // and take the area sign and magnitude. A zero area marks the cell as
    // degenerate.
    // ------------------------------------------------------------------------
    logic signed [MW-1:0] r4_mxk [4];
    logic signed [MW-1:0] r4_myk [4];
    logic signed [DW-1:0] r4_den;
    logic                 r4_deg;
    logic                 r4_aneg;
    logic [TW-1:0]        r4_amag;
    logic [W-1:0]         r4_avgx;
    logic [W-1:0]         r4_avgy;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            for (int k = 0; k < 4; k++) begin
                r4_mxk[k] <= $signed({r3_phx[k], {W{1'b0}}}) + r3_plx[k];
                r4_myk[k] <= $signed({r3_phy[k], {W{1'b0}}}) + r3_ply[k];
            end
            r4_den  <= $signed({r3_twice, 1'b0}) + r3_twice;
            r4_deg  <= (r3_twice == '0);
            r4_aneg <= r3_twice[TW-1];
            r4_amag <= r3_twice[TW-1] ? -r3_twice : r3_twice;
            r4_avgx <= r3_avgx;
            r4_avgy <= r3_avgy;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: the first-moment sums, and the area halved toward zero and
    // saturated to the output field.
    // ------------------------------------------------------------------------
    logic signed [NMW-1:0] r5_mx;
    logic signed [NMW-1:0] r5_my;
    logic signed [DW-1:0]  r5_den;
    logic                  r5_deg;
    logic [AW-1:0]         r5_area;
    logic [W-1:0]          r5_avgx;
    logic [W-1:0]          r5_avgy;
    logic [HAW-1:0]        area_sat;

    assign area_sat = (r4_amag[TW-1:1] > ALIM) ? ALIM : r4_amag[TW-1:1];

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r5_mx   <= r4_mxk[0] + r4_mxk[1] + r4_mxk[2] + r4_mxk[3];
            r5_my   <= r4_myk[0] + r4_myk[1] + r4_myk[2] + r4_myk[3];
            r5_den  <= r4_den;
            r5_deg  <= r4_deg;
            r5_area <= r4_aneg ? -area_sat[AW-1:0] : area_sat[AW-1:0];
            r5_avgx <= r4_avgx;
            r5_avgy <= r4_avgy;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: magnitudes and quotient signs for the divider.
    // ------------------------------------------------------------------------
    logic [NMW-1:0] r6_nx;
    logic [NMW-1:0] r6_ny;
    logic [DW-1:0]  r6_d;
    logic           r6_negx;
    logic           r6_negy;
    logic           r6_deg;
    logic [AW-1:0]  r6_area;
    logic [W-1:0]   r6_avgx;
    logic [W-1:0]   r6_avgy;

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r6_nx   <= r5_mx[NMW-1] ? -r5_mx : r5_mx;
            r6_ny   <= r5_my[NMW-1] ? -r5_my : r5_my;
            r6_d    <= r5_den[DW-1] ? -r5_den : r5_den;
            r6_negx <= r5_mx[NMW-1] ^ r5_den[DW-1];
            r6_negy <= r5_my[NMW-1] ^ r5_den[DW-1];
            r6_deg  <= r5_deg;
            r6_area <= r5_area;
            r6_avgx <= r5_avgx;
            r6_avgy <= r5_avgy;
        end
    end

    // ------------------------------------------------------------------------
    // Divider and output register. The result holds in the divider's output
    // register until the downstream transfer completes.
    // ------------------------------------------------------------------------
    qac_div #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[NF-1]),
        .o_ready (div_ready),
        .i_num_x (r6_nx),
        .i_num_y (r6_ny),
        .i_den   (r6_d),
        .i_neg_x (r6_negx),
        .i_neg_y (r6_negy),
        .i_deg   (r6_deg),
        .i_avg_x (r6_avgx),
        .i_avg_y (r6_avgy),
        .i_area  (r6_area),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_area  (o_signed_area),
        .o_cx    (o_centroid_x),
        .o_cy    (o_centroid_y),
        .o_deg   (o_degenerate)
    );

endmodule
